// ----- hw/rtl/hjb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join package
// Field widths, operation codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hjb_pkg;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 13;
  localparam int MC_W    = 13;
  localparam int TOT_W   = 32;
  localparam int RADIX_W = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd4;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_PROBE = 2'd2;

  typedef struct packed {
    logic load_item;
    logic start_part;
    logic clr_en;
    logic head_rd;
    logic build_wr;
    logic flag_ovf;
    logic walk_first;
    logic walk_step;
    logic result_load;
  } hjb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            head_zero;
    logic            link_zero;
    logic            clr_last;
  } hjb_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hjb_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join input channel
// Valid/ready channel carrying one operation with its key and build count.
// ----------------------------------------------------------------------------
interface hjb_in_if;
  logic                     valid;
  logic                     ready;
  logic [hjb_pkg::OP_W-1:0]  op;
  logic [hjb_pkg::KEY_W-1:0] key;
  logic [hjb_pkg::CNT_W-1:0] build_count;

  modport source (output valid, output op, output key, output build_count, input ready);
  modport sink   (input valid, input op, input key, input build_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hjb_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join result channel
// Valid/ready channel carrying the match count, running total and overflow.
// ----------------------------------------------------------------------------
interface hjb_out_if;
  logic                     valid;
  logic                     ready;
  logic [hjb_pkg::MC_W-1:0]  match_count;
  logic [hjb_pkg::TOT_W-1:0] total_matches;
  logic                     overflow;

  modport source (output valid, output match_count, output total_matches,
                  output overflow, input ready);
  modport sink   (input valid, input match_count, input total_matches,
                  input overflow, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/hash_join_bucket_chaining.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join by bucket chaining
// Builds bucket chains of one partition and probes them, keeping a running
// match total.
// ----------------------------------------------------------------------------
//  Channel      Direction  Transaction
//  in_item      in         op, key, build_count
//  out_result   out        match_count, total_matches, overflow
//  cfg_we/wdata in         radix_shift write, no handshake
//
// A build reads the bucket head and then writes the entry, a probe reads the
// bucket head and then walks its chain (one entry-store read a cycle), an
// unused op goes straight to its result, and a start clears the bucket-head memory one entry a cycle.
// After reset the same pass clears the whole memory before the first
// transaction is taken. The result register lets the next transaction in
// while a result still waits on out_result.ready.
// ----------------------------------------------------------------------------
module hash_join_bucket_chaining #(
  parameter int MAX_BUILD_TUPLES = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  hjb_in_if.sink                            in_item,
  hjb_out_if.source                         out_result,
  input  wire logic                         cfg_we,
  input  wire logic [hjb_pkg::RADIX_W-1:0]  cfg_wdata
);
  import hjb_pkg::*;

  hjb_cmd_t    cmd;
  hjb_status_t status;
  logic        in_ready;
  logic        out_valid;

  hjb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_op     (in_item.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hjb_dpath #(
    .MAX_BUILD_TUPLES (MAX_BUILD_TUPLES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_op             (in_item.op),
    .in_key            (in_item.key),
    .in_build_count    (in_item.build_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_match_count   (out_result.match_count),
    .out_total_matches (out_result.total_matches),
    .out_overflow      (out_result.overflow)
  );

  assign in_item.ready    = in_ready;
  assign out_result.valid = out_valid;

endmodule
`default_nettype wire

// ----- hw/rtl/hjb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hjb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/hjb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join controller
// Sequences head-table clearing, build inserts and probe chain walks, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module hjb_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [hjb_pkg::OP_W-1:0]  in_op,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire hjb_pkg::hjb_status_t      status,
  output hjb_pkg::hjb_cmd_t              cmd
);
  import hjb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_CLEAR,
    S_HEAD_RD,
    S_HEAD_USE,
    S_WALK,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_INIT: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          unique case (in_op) inside
            OP_START:           state_nxt = S_START;
            OP_BUILD, OP_PROBE: state_nxt = S_HEAD_RD;
            default:            state_nxt = S_RESULT;
          endcase
        end
      end
      S_START: begin
        cmd.start_part = 1'b1;
        state_nxt      = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD_USE;
      end
      S_HEAD_USE: begin
        if (status.op == OP_BUILD) begin
          if (status.full) begin
            cmd.flag_ovf = 1'b1;
          end else begin
            cmd.build_wr = 1'b1;
          end
          state_nxt = S_RESULT;
        end else if (status.head_zero) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.walk_first = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        // Each cycle compares one chain entry and fetches the next one.
        cmd.walk_step = 1'b1;
        if (status.link_zero) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/hjb_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Hash join datapath
// Bucket-head table, entry store of keys and chain links, counters, the
// running total and the result register.
// ----------------------------------------------------------------------------
module hjb_dpath #(
  parameter int MAX_BUILD_TUPLES = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hjb_pkg::hjb_cmd_t            cmd,
  output hjb_pkg::hjb_status_t              status,
  input  wire logic [hjb_pkg::OP_W-1:0]     in_op,
  input  wire logic [hjb_pkg::KEY_W-1:0]    in_key,
  input  wire logic [hjb_pkg::CNT_W-1:0]    in_build_count,
  input  wire logic                         cfg_we,
  input  wire logic [hjb_pkg::RADIX_W-1:0]  cfg_wdata,
  output logic      [hjb_pkg::MC_W-1:0]     out_match_count,
  output logic      [hjb_pkg::TOT_W-1:0]    out_total_matches,
  output logic                              out_overflow
);
  import hjb_pkg::*;

  localparam int IDX_W = $clog2(MAX_BUILD_TUPLES);
  localparam int PTR_W = $clog2(MAX_BUILD_TUPLES + 1);
  localparam int CW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int ENT_W = KEY_W + PTR_W;

  // Mask is the next power of two at or above the count, less one, capped
  // at the store size.
  function automatic logic [IDX_W-1:0] mask_of(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] v;
    logic [CW-1:0]    s;
    logic [CW-1:0]    lim;
    v   = c - CNT_W'(1);
    v   = v | (v >> 1);
    v   = v | (v >> 2);
    v   = v | (v >> 4);
    v   = v | (v >> 8);
    s   = CW'(v);
    lim = CW'(MAX_BUILD_TUPLES - 1);
    if (c <= CNT_W'(1)) begin
      s = '0;
    end else if (s > lim) begin
      s = lim;
    end
    return s[IDX_W-1:0];
  endfunction

  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [CNT_W-1:0]   count_r;
  logic [RADIX_W-1:0] radix_r;
  logic [IDX_W-1:0]   mask_r;
  logic [PTR_W-1:0]   tuples_r;
  logic [TOT_W-1:0]   total_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [PTR_W-1:0]   found_r;
  logic               ovf_r;
  logic [MC_W-1:0]    out_match_r;
  logic [TOT_W-1:0]   out_total_r;
  logic               out_ovf_r;

  logic [KEY_W-1:0]   shifted;
  logic [IDX_W-1:0]   bucket;
  logic               head_we;
  logic [IDX_W-1:0]   head_waddr;
  logic [PTR_W-1:0]   head_wdata;
  logic [PTR_W-1:0]   head_rdata;
  logic [PTR_W-1:0]   head_m1;
  logic               ent_re;
  logic [IDX_W-1:0]   ent_raddr;
  logic [ENT_W-1:0]   ent_rdata;
  logic [KEY_W-1:0]   ent_key;
  logic [PTR_W-1:0]   ent_link;
  logic [PTR_W-1:0]   link_m1;
  logic [TOT_W-1:0]   total_sum;
  logic               clr_last;

  assign shifted  = key_r >> radix_r;
  assign bucket   = shifted[IDX_W-1:0] & mask_r;
  assign clr_last = (clr_cnt_r == IDX_W'(MAX_BUILD_TUPLES - 1));

  assign head_we    = cmd.clr_en | cmd.build_wr;
  assign head_waddr = cmd.clr_en ? clr_cnt_r : bucket;
  assign head_wdata = cmd.clr_en ? '0 : (tuples_r + PTR_W'(1));

  assign head_m1   = head_rdata - PTR_W'(1);
  assign ent_key   = ent_rdata[ENT_W-1 -: KEY_W];
  assign ent_link  = ent_rdata[PTR_W-1:0];
  assign link_m1   = ent_link - PTR_W'(1);
  assign ent_re    = cmd.walk_first | cmd.walk_step;
  assign ent_raddr = cmd.walk_first ? head_m1[IDX_W-1:0] : link_m1[IDX_W-1:0];
  assign total_sum = total_r + TOT_W'(found_r);

  hjb_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_BUILD_TUPLES)
  ) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (cmd.head_rd),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  // Key and link of an entry are written together and read together.
  hjb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BUILD_TUPLES)
  ) u_entries (
    .clk   (clk),
    .we    (cmd.build_wr),
    .waddr (tuples_r[IDX_W-1:0]),
    .wdata ({key_r, head_rdata}),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign status.op        = op_r;
  assign status.full      = (tuples_r == PTR_W'(MAX_BUILD_TUPLES));
  assign status.head_zero = (head_rdata == '0);
  assign status.link_zero = (ent_link == '0);
  assign status.clr_last  = clr_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= RADIX_RESET;
      mask_r    <= '0;
      tuples_r  <= '0;
      total_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_last ? '0 : (clr_cnt_r + IDX_W'(1));
      end
      if (cmd.start_part) begin
        mask_r   <= mask_of(count_r);
        tuples_r <= '0;
        total_r  <= '0;
      end else if (cmd.build_wr) begin
        tuples_r <= tuples_r + PTR_W'(1);
      end else if (cmd.result_load) begin
        total_r <= total_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= in_op;
      key_r   <= in_key;
      count_r <= in_build_count;
      found_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.walk_step && (ent_key == key_r)) begin
        found_r <= found_r + PTR_W'(1);
      end
      if (cmd.flag_ovf) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.result_load) begin
      out_match_r <= MC_W'(found_r);
      out_total_r <= total_sum;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_match_count   = out_match_r;
  assign out_total_matches = out_total_r;
  assign out_overflow      = out_ovf_r;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash join bucket chaining testbench
// Sends start, build, probe and unused operations over the input channel and
// checks every result against a behavioural copy of the join kept alongside.
// The checks cover runs with no start, store overflow, mask saturation and
// changes of the radix shift, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import hjb_pkg::*;

  localparam int MAX_TUPLES  = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] build_count;
  } join_item_t;

  typedef struct packed {
    logic [MC_W-1:0]  match_count;
    logic [TOT_W-1:0] total_matches;
    logic             overflow;
  } join_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  hjb_in_if  in_ch();
  hjb_out_if out_ch();

  hash_join_bucket_chaining #(.MAX_BUILD_TUPLES(MAX_TUPLES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_ch),
    .out_result (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow of the join state, updated as each transaction is accepted.
  logic [CNT_W-1:0]   bucket_heads [MAX_TUPLES];
  logic [CNT_W-1:0]   chain_links  [MAX_TUPLES];
  logic [KEY_W-1:0]   stored_keys  [MAX_TUPLES];
  logic [CNT_W-1:0]   tuples_built;
  logic [11:0]        bucket_mask;
  logic [TOT_W-1:0]   match_total;
  logic [RADIX_W-1:0] radix_shift;

  join_result_t pending_join_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int results_checked;
  int partitions_started;
  int radix_writes;
  int overflows_seen;
  int probe_hits;
  int mismatch_count;
  int cycle_count;

  function automatic logic [11:0] mask_for(input logic [CNT_W-1:0] count);
    int span;
    span = 1;
    while (span < int'(count) && span < MAX_TUPLES) span = span << 1;
    return 12'(span - 1);
  endfunction

  function automatic join_result_t compute_join_result(input join_item_t item);
    join_result_t     res;
    logic [11:0]      bucket;
    logic [CNT_W-1:0] link;
    int               steps;
    res    = '0;
    bucket = 12'((item.key >> radix_shift) & 32'(bucket_mask));
    case (item.op)
      OP_START: begin
        foreach (bucket_heads[i]) bucket_heads[i] = '0;
        tuples_built = '0;
        match_total  = '0;
        bucket_mask  = mask_for(item.build_count);
      end
      OP_BUILD: begin
        if (int'(tuples_built) >= MAX_TUPLES) begin
          res.overflow = 1'b1;
        end else begin
          stored_keys[tuples_built] = item.key;
          chain_links[tuples_built] = bucket_heads[bucket];
          bucket_heads[bucket]      = tuples_built + 1'b1;
          tuples_built              = tuples_built + 1'b1;
        end
      end
      OP_PROBE: begin
        link  = bucket_heads[bucket];
        steps = 0;
        while (link != '0 && steps < MAX_TUPLES) begin
          if (stored_keys[link - 1'b1] == item.key) res.match_count = res.match_count + 1'b1;
          link  = chain_links[link - 1'b1];
          steps = steps + 1;
        end
        match_total = match_total + 32'(res.match_count);
      end
      default: ;
    endcase
    res.total_matches = match_total;
    return res;
  endfunction

  function automatic void note_field(input string field, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 60)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(11))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    case ($urandom_range(4))
      0:       return 5'd0;
      1:       return 5'd31;
      2:       return 5'd16;
      3:       return RADIX_RESET;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  // Entered and left on a falling edge; valid stays high on exit so that
  // back-to-back transactions need no second assignment in one time step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [CNT_W-1:0] count);
    join_item_t item;
    item.op          = op;
    item.key         = key;
    item.build_count = count;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.key         <= key;
    in_ch.build_count <= count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_join_results.push_back(compute_join_result(item));
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_START) partitions_started++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_join_results.size() != 0);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    radix_shift  = value;
    radix_writes++;
    @(negedge clk);
  endtask

  task automatic maybe_unused_op();
    if ($urandom_range(11) == 0) send_item(OP_UNUSED, $urandom(), 13'($urandom()));
  endtask

  // Builds and probes before any start run on the reset state: one bucket.
  task automatic test_without_start();
    send_item(OP_BUILD, 32'hFFFF_FFFF, '0);
    send_item(OP_BUILD, 32'h1234_5670, 13'h1FFF);
    send_item(OP_PROBE, 32'hFFFF_FFFF, '0);
    send_item(OP_PROBE, 32'h0000_0000, '0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 13'h1FFF);
  endtask

  task automatic test_directed_cases();
    // A count of zero still gives a single bucket; duplicates must both hit.
    send_item(OP_START, '0, 13'd0);
    send_item(OP_BUILD, 32'h0000_0000, '0);
    send_item(OP_BUILD, 32'hFFFF_FFFF, '0);
    send_item(OP_BUILD, 32'h0000_0000, '0);
    send_item(OP_PROBE, 32'h0000_0000, '0);
    send_item(OP_PROBE, 32'hFFFF_FFFF, '0);
    send_item(OP_PROBE, 32'h0000_0001, '0);
    send_item(OP_START, '0, 13'd1);
    send_item(OP_BUILD, 32'hA5A5_A5A5, '0);
    send_item(OP_PROBE, 32'hA5A5_A5A5, '0);
    // The largest count saturates the mask at the store size.
    send_item(OP_START, 32'hFFFF_FFFF, 13'h1FFF);
    send_item(OP_BUILD, 32'h0000_FFF0, '0);
    send_item(OP_PROBE, 32'h0000_FFF0, '0);
    send_item(OP_START, '0, 13'd5);
    send_item(OP_BUILD, 32'h0000_0010, '0);
    send_item(OP_BUILD, 32'h0000_0020, '0);
    send_item(OP_BUILD, 32'h0000_0010, '0);
    send_item(OP_PROBE, 32'h0000_0010, '0);
    send_item(OP_PROBE, 32'h0000_0030, '0);
    send_item(OP_UNUSED, '0, '0);
  endtask

  // Fill the store completely, then check that further builds are dropped.
  task automatic test_store_capacity();
    logic [KEY_W-1:0] key_pool [$];
    wait_for_results();
    write_radix(5'd0);
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    repeat (700) key_pool.push_back($urandom());
    send_item(OP_START, $urandom(), 13'd4096);
    repeat (MAX_TUPLES) send_item(OP_BUILD, key_pool[$urandom_range(key_pool.size() - 1)], '0);
    send_item(OP_BUILD, 32'hFFFF_FFFF, '0);
    send_item(OP_BUILD, $urandom(), '0);
    send_item(OP_BUILD, 32'h0000_0000, '0);
    repeat (16) begin
      if ($urandom_range(3) != 0)
        send_item(OP_PROBE, key_pool[$urandom_range(key_pool.size() - 1)], '0);
      else
        send_item(OP_PROBE, $urandom(), '0);
    end
  endtask

  task automatic run_partition();
    logic [KEY_W-1:0] key_pool [$];
    logic [CNT_W-1:0] count;
    int               n_build;
    n_build = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
    case ($urandom_range(9))
      0:       count = '0;
      1:       count = 13'($urandom_range(4097, 8191));
      2:       count = 13'($urandom_range(0, 8191));
      3:       count = 13'(n_build / 3);
      default: count = 13'(n_build);
    endcase
    repeat ($urandom_range(1, n_build)) key_pool.push_back(random_key());
    // Now and then the start is left out, so the builds extend the last store.
    if ($urandom_range(7) != 0) send_item(OP_START, $urandom(), count);
    repeat (n_build) begin
      maybe_unused_op();
      send_item(OP_BUILD, key_pool[$urandom_range(key_pool.size() - 1)], 13'($urandom()));
    end
    // A new shift between build and probe sends probes to other buckets.
    if ($urandom_range(5) == 0) begin
      wait_for_results();
      write_radix(random_radix());
    end
    repeat ($urandom_range(1, 30)) begin
      maybe_unused_op();
      if ($urandom_range(14) == 0)
        send_item(OP_BUILD, random_key(), 13'($urandom()));
      else if ($urandom_range(3) != 0)
        send_item(OP_PROBE, key_pool[$urandom_range(key_pool.size() - 1)], 13'($urandom()));
      else
        send_item(OP_PROBE, random_key(), 13'($urandom()));
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int quota);
    int first_count;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first_count    = items_sent;
    while (items_sent - first_count < quota) begin
      wait_for_results();
      write_radix(random_radix());
      run_partition();
    end
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    join_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_join_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 60)
          $display("%0t: result with none expected, got count %0h total %0h overflow %0b",
                   $time, out_ch.match_count, out_ch.total_matches, out_ch.overflow);
      end else begin
        want = pending_join_results.pop_front();
        note_field("match_count", 32'(want.match_count), 32'(out_ch.match_count));
        note_field("total_matches", want.total_matches, out_ch.total_matches);
        note_field("overflow", 32'(want.overflow), 32'(out_ch.overflow));
        results_checked++;
        if (out_ch.overflow === 1'b1) overflows_seen++;
        if (out_ch.match_count != '0) probe_hits++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending_join_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_START;
    in_ch.key         = '0;
    in_ch.build_count = '0;
    out_ch.ready      = 1'b0;
    foreach (bucket_heads[i]) begin
      bucket_heads[i] = '0;
      chain_links[i]  = '0;
      stored_keys[i]  = '0;
    end
    tuples_built   = '0;
    bucket_mask    = '0;
    match_total    = '0;
    radix_shift    = RADIX_RESET;
    send_idle_pct  = 17;
    recv_stall_pct = 82;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_without_start();
    test_directed_cases();
    test_random_phase(17, 82, 135);
    test_random_phase(82, 17, 135);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_store_capacity();
    test_random_phase(0, 0, 135);

    wait_for_results();
    repeat (64) @(negedge clk);
    $display("Checked %0d results from %0d transactions over %0d partitions and %0d shifts.",
             results_checked, items_sent, partitions_started, radix_writes);
    $display("Saw %0d dropped builds and %0d probes with matches in %0d cycles.",
             overflows_seen, probe_hits, cycle_count);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
